>>> design/mwsm_pkg.sv
// Package with the constants, sine table, stage types and helper functions of the wheel mixer.
package mwsm_pkg;

  // Command codes on the op field.
  typedef enum logic [1:0] {
    OP_TRANSLATE  = 2'd0,
    OP_TURN_LEFT  = 2'd1,
    OP_TURN_RIGHT = 2'd2,
    OP_STOP       = 2'd3
  } op_t;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int ANGLE_W = 10;
  localparam int SPEED_W = 8;
  localparam int WHEEL_W = 8;
  localparam int DEG_W   = 9;   // Reduced angle, 0..359.
  localparam int REM_W   = 7;   // Remainder within a quadrant, 0..89, or table index, 0..90.
  localparam int SUM_W   = WHEEL_W + 1;

  // Speed saturation limit.
  localparam int SPEED_LIMIT = 100;

  // Sine format: table is stored in unsigned Q1.14 and rescaled to SINE_FRACTION_BITS.
  localparam int TABLE_FRACTION_BITS = 14;
  localparam int SINE_FRACTION_BITS  = 14;
  localparam int SINE_W  = SINE_FRACTION_BITS + 2;
  localparam int PROD_W  = SPEED_W + SINE_W;
  localparam int SHIFT_UP = (SINE_FRACTION_BITS >= TABLE_FRACTION_BITS) ?
                            SINE_FRACTION_BITS - TABLE_FRACTION_BITS : 0;
  localparam int SHIFT_DN = (SINE_FRACTION_BITS < TABLE_FRACTION_BITS) ?
                            TABLE_FRACTION_BITS - SINE_FRACTION_BITS : 0;
  localparam int HALF_DN  = (SHIFT_DN > 0) ? (1 << (SHIFT_DN - 1)) : 0;

  // Angle constants in degrees.
  localparam int DEG_90  = 90;
  localparam int DEG_180 = 180;
  localparam int DEG_270 = 270;
  localparam int DEG_360 = 360;

  // Quarter-wave sine, round(16384*sin(d)) for d = 0..90 degrees.
  localparam logic [14:0] QUARTER_SINE [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Stage 1: clamped speed, translate flag and reduced angle.
  typedef struct packed {
    logic                      xlate;
    logic signed [WHEEL_W-1:0] spd;
    logic [DEG_W-1:0]          deg;
  } st1_t;

  // Stage 2: sine and cosine of the angle.
  typedef struct packed {
    logic                      xlate;
    logic signed [WHEEL_W-1:0] spd;
    logic signed [SINE_W-1:0]  sin_v;
    logic signed [SINE_W-1:0]  cos_v;
  } st2_t;

  // Stage 3: raw products of speed and sine or cosine.
  typedef struct packed {
    logic                      xlate;
    logic signed [WHEEL_W-1:0] spd;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
  } st3_t;

  // Saturate a sum to the speed limit.
  function automatic logic signed [WHEEL_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] v);
    logic signed [WHEEL_W-1:0] r;
    if (v > SUM_W'(SPEED_LIMIT)) begin
      r = WHEEL_W'(SPEED_LIMIT);
    end else if (v < -SUM_W'(SPEED_LIMIT)) begin
      r = -WHEEL_W'(SPEED_LIMIT);
    end else begin
      r = v[WHEEL_W-1:0];
    end
    return r;
  endfunction

  // Table entry rescaled to the working sine format, with its sign applied.
  function automatic logic signed [SINE_W-1:0] sine_entry(input logic [REM_W-1:0] idx,
                                                          input logic neg);
    logic [31:0] t;
    logic [31:0] sc;
    t = 32'(QUARTER_SINE[idx]);
    if (SINE_FRACTION_BITS >= TABLE_FRACTION_BITS) begin
      sc = t << SHIFT_UP;
    end else begin
      sc = (t + 32'(HALF_DN)) >> SHIFT_DN;
    end
    return neg ? -SINE_W'(sc) : SINE_W'(sc);
  endfunction

  // Divide a product by 2^SINE_FRACTION_BITS, rounding halves away from zero.
  function automatic logic signed [SUM_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    q   = (mag + (PROD_W'(1) << (SINE_FRACTION_BITS - 1))) >> SINE_FRACTION_BITS;
    return p[PROD_W-1] ? -SUM_W'(q) : SUM_W'(q);
  endfunction

endpackage

>>> design/mecanum_wheel_speed_mixer_top.sv
// Top level of the mecanum wheel speed mixer: a four-stage pipeline from command to wheel speeds.
// The mixer takes one drive command per cycle unless the output side stalls it, and returns four
// saturated wheel speeds. An item passes four register stages (angle reduction and speed clamp,
// quarter-wave sine and cosine lookup, the two multiplies, rounding and wheel mixing into the
// output register). When the output side keeps ready high, one item per cycle is sustained.
// Each stage holds its item while the stage after it is full
// and stalled; in_ready is high whenever out_ready is high. Translate yields y+x, y-x, y-x, y+x
// with x and y the rounded sine and cosine parts; turns yield s, -s, s, -s or its negation;
// stop yields zeros. The block keeps no state between items.
module mecanum_wheel_speed_mixer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mwsm_pkg::OP_W-1:0]            in_op,
  input  logic signed [mwsm_pkg::ANGLE_W-1:0]  in_angle_degrees,
  input  logic signed [mwsm_pkg::SPEED_W-1:0]  in_speed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_one_speed,
  output logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_two_speed,
  output logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_three_speed,
  output logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_four_speed
);

  localparam int AW = mwsm_pkg::ANGLE_W + 2;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  mwsm_pkg::st1_t s1_r, s1_nxt;
  mwsm_pkg::st2_t s2_r, s2_nxt;
  mwsm_pkg::st3_t s3_r, s3_nxt;

  logic signed [mwsm_pkg::WHEEL_W-1:0] w1_r, w2_r, w3_r, w4_r;
  logic signed [mwsm_pkg::WHEEL_W-1:0] w1_nxt, w2_nxt, w3_nxt, w4_nxt;

  // Each stage may load when it is empty or its contents move on.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: pick and clamp the signed speed, and reduce the angle to 0..359.
  always_comb begin
    logic signed [mwsm_pkg::SUM_W-1:0] s_raw;
    logic [AW-1:0]                     a_off;
    mwsm_pkg::op_t                     op;
    op    = mwsm_pkg::op_t'(in_op);
    s_raw = mwsm_pkg::SUM_W'(in_speed);
    unique case (op) inside
      mwsm_pkg::OP_TRANSLATE,
      mwsm_pkg::OP_TURN_LEFT:  s_raw = mwsm_pkg::SUM_W'(in_speed);
      mwsm_pkg::OP_TURN_RIGHT: s_raw = -mwsm_pkg::SUM_W'(in_speed);
      mwsm_pkg::OP_STOP:       s_raw = '0;
      default:                 s_raw = '0;
    endcase
    s1_nxt.xlate = (op == mwsm_pkg::OP_TRANSLATE);
    s1_nxt.spd   = mwsm_pkg::clamp_sum(s_raw);
    // The offset of two full turns makes the value non-negative.
    a_off = AW'(in_angle_degrees) + AW'(2 * mwsm_pkg::DEG_360);
    if (a_off >= AW'(3 * mwsm_pkg::DEG_360)) begin
      a_off = a_off - AW'(3 * mwsm_pkg::DEG_360);
    end else if (a_off >= AW'(2 * mwsm_pkg::DEG_360)) begin
      a_off = a_off - AW'(2 * mwsm_pkg::DEG_360);
    end else if (a_off >= AW'(mwsm_pkg::DEG_360)) begin
      a_off = a_off - AW'(mwsm_pkg::DEG_360);
    end
    s1_nxt.deg = a_off[mwsm_pkg::DEG_W-1:0];
  end

  // Stage 2: split into quadrant and remainder; cosine uses the next quadrant.
  always_comb begin
    logic [1:0]                 q;
    logic [1:0]                 qc;
    logic [mwsm_pkg::DEG_W-1:0] r9;
    logic [mwsm_pkg::REM_W-1:0] r;
    logic [mwsm_pkg::REM_W-1:0] ninety;
    if (s1_r.deg >= mwsm_pkg::DEG_W'(mwsm_pkg::DEG_270)) begin
      q  = 2'd3;
      r9 = s1_r.deg - mwsm_pkg::DEG_W'(mwsm_pkg::DEG_270);
    end else if (s1_r.deg >= mwsm_pkg::DEG_W'(mwsm_pkg::DEG_180)) begin
      q  = 2'd2;
      r9 = s1_r.deg - mwsm_pkg::DEG_W'(mwsm_pkg::DEG_180);
    end else if (s1_r.deg >= mwsm_pkg::DEG_W'(mwsm_pkg::DEG_90)) begin
      q  = 2'd1;
      r9 = s1_r.deg - mwsm_pkg::DEG_W'(mwsm_pkg::DEG_90);
    end else begin
      q  = 2'd0;
      r9 = s1_r.deg;
    end
    r      = r9[mwsm_pkg::REM_W-1:0];
    ninety = mwsm_pkg::REM_W'(mwsm_pkg::DEG_90);
    qc     = q + 2'd1;
    s2_nxt.xlate = s1_r.xlate;
    s2_nxt.spd   = s1_r.spd;
    s2_nxt.sin_v = mwsm_pkg::sine_entry(q[0] ? ninety - r : r, q[1]);
    s2_nxt.cos_v = mwsm_pkg::sine_entry(qc[0] ? ninety - r : r, qc[1]);
  end

  // Stage 3: the two multiplies.
  always_comb begin
    s3_nxt.xlate  = s2_r.xlate;
    s3_nxt.spd    = s2_r.spd;
    s3_nxt.prod_x = mwsm_pkg::PROD_W'(s2_r.spd) * mwsm_pkg::PROD_W'(s2_r.sin_v);
    s3_nxt.prod_y = mwsm_pkg::PROD_W'(s2_r.spd) * mwsm_pkg::PROD_W'(s2_r.cos_v);
  end

  // Stage 4: round, mix and clamp, or spread the turn speed.
  always_comb begin
    logic signed [mwsm_pkg::SUM_W-1:0] x;
    logic signed [mwsm_pkg::SUM_W-1:0] y;
    logic signed [mwsm_pkg::WHEEL_W-1:0] sum_w;
    logic signed [mwsm_pkg::WHEEL_W-1:0] dif_w;
    x     = mwsm_pkg::round_prod(s3_r.prod_x);
    y     = mwsm_pkg::round_prod(s3_r.prod_y);
    sum_w = mwsm_pkg::clamp_sum(y + x);
    dif_w = mwsm_pkg::clamp_sum(y - x);
    if (s3_r.xlate) begin
      w1_nxt = sum_w;
      w2_nxt = dif_w;
      w3_nxt = dif_w;
      w4_nxt = sum_w;
    end else begin
      w1_nxt = s3_r.spd;
      w2_nxt = -s3_r.spd;
      w3_nxt = s3_r.spd;
      w4_nxt = -s3_r.spd;
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage payloads load only when the stage is free to take the next item.
  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) begin
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
      w3_r <= w3_nxt;
      w4_r <= w4_nxt;
    end
  end

  assign out_valid             = v4_r;
  assign out_wheel_one_speed   = w1_r;
  assign out_wheel_two_speed   = w2_r;
  assign out_wheel_three_speed = w3_r;
  assign out_wheel_four_speed  = w4_r;

endmodule

>>> design/mwsm_checker.sv
// Port-level checker for the wheel mixer, with its bind to the top level.
module mwsm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mwsm_pkg::WHEEL_W-1:0] out_wheel_one_speed,
  input logic signed [mwsm_pkg::WHEEL_W-1:0] out_wheel_two_speed,
  input logic signed [mwsm_pkg::WHEEL_W-1:0] out_wheel_three_speed,
  input logic signed [mwsm_pkg::WHEEL_W-1:0] out_wheel_four_speed
);

  localparam logic signed [mwsm_pkg::WHEEL_W-1:0] LIM = mwsm_pkg::WHEEL_W'(mwsm_pkg::SPEED_LIMIT);

  // A ready output side never blocks the input side.
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // With no back-pressure an accepted item passes through every stage and comes out as a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("item did not reach the output in four cycles");

  // Every delivered wheel speed is within the limit.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wheel_one_speed <= LIM) && (out_wheel_one_speed >= -LIM)
              && (out_wheel_two_speed <= LIM) && (out_wheel_two_speed >= -LIM)
              && (out_wheel_three_speed <= LIM) && (out_wheel_three_speed >= -LIM)
              && (out_wheel_four_speed <= LIM) && (out_wheel_four_speed >= -LIM))
    else $error("wheel speed beyond limit");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_wheel_one_speed)
      && $stable(out_wheel_two_speed) && $stable(out_wheel_three_speed)
      && $stable(out_wheel_four_speed))
    else $error("stalled result changed");

endmodule

bind mecanum_wheel_speed_mixer_top mwsm_checker u_mwsm_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_wheel_one_speed   (out_wheel_one_speed),
  .out_wheel_two_speed   (out_wheel_two_speed),
  .out_wheel_three_speed (out_wheel_three_speed),
  .out_wheel_four_speed  (out_wheel_four_speed)
);

>>> verif/wheel_speed_checker.sv
// Checker for the wheel mixer: watches both channels, predicts wheel speeds and compares them.
module wheel_speed_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [mwsm_pkg::OP_W-1:0]            in_op,
  input  logic signed [mwsm_pkg::ANGLE_W-1:0]  in_angle_degrees,
  input  logic signed [mwsm_pkg::SPEED_W-1:0]  in_speed,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_one_speed,
  input  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_two_speed,
  input  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_three_speed,
  input  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_four_speed,
  output int                                   fail_count,
  output int                                   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Four wheel speeds of one result item.
  typedef struct packed {
    logic signed [mwsm_pkg::WHEEL_W-1:0] one;
    logic signed [mwsm_pkg::WHEEL_W-1:0] two;
    logic signed [mwsm_pkg::WHEEL_W-1:0] three;
    logic signed [mwsm_pkg::WHEEL_W-1:0] four;
  } wheel_speeds_t;

  wheel_speeds_t expected_wheels[$];
  int            result_index;

  // Saturate to the speed limit.
  function automatic int clamp_to_limit(input int v);
    if (v > mwsm_pkg::SPEED_LIMIT) return mwsm_pkg::SPEED_LIMIT;
    if (v < -mwsm_pkg::SPEED_LIMIT) return -mwsm_pkg::SPEED_LIMIT;
    return v;
  endfunction

  // Quarter-wave table entry in the working sine format.
  function automatic longint table_scaled(input int d);
    longint t;
    int     sh;
    t = longint'(mwsm_pkg::QUARTER_SINE[d]);
    if (mwsm_pkg::SINE_FRACTION_BITS >= mwsm_pkg::TABLE_FRACTION_BITS) begin
      sh = mwsm_pkg::SINE_FRACTION_BITS - mwsm_pkg::TABLE_FRACTION_BITS;
      return t << sh;
    end
    sh = mwsm_pkg::TABLE_FRACTION_BITS - mwsm_pkg::SINE_FRACTION_BITS;
    return (t + (64'sd1 << (sh - 1))) >>> sh;
  endfunction

  // Sine of an angle already reduced to 0..359, from quarter-wave symmetry.
  function automatic longint sine_of_degrees(input int a);
    int quadrant;
    int rem;
    quadrant = a / 90;
    rem      = a % 90;
    case (quadrant)
      0:       return table_scaled(rem);
      1:       return table_scaled(90 - rem);
      2:       return -table_scaled(rem);
      default: return -table_scaled(90 - rem);
    endcase
  endfunction

  // Speed times sine, scaled back to an integer with halves away from zero.
  function automatic int round_scaled(input int s, input longint f);
    longint p;
    longint mag;
    p   = longint'(s) * f;
    mag = (p < 0) ? -p : p;
    mag = (mag + (64'sd1 << (mwsm_pkg::SINE_FRACTION_BITS - 1))) >>> mwsm_pkg::SINE_FRACTION_BITS;
    return (p < 0) ? -int'(mag) : int'(mag);
  endfunction

  // Wheel speeds that one drive command should produce.
  function automatic wheel_speeds_t mix_wheel_speeds(
      input logic [mwsm_pkg::OP_W-1:0]           op,
      input logic signed [mwsm_pkg::ANGLE_W-1:0] ang,
      input logic signed [mwsm_pkg::SPEED_W-1:0] spd);
    wheel_speeds_t w;
    int            s;
    int            m;
    int            x;
    int            y;
    w = '0;
    case (mwsm_pkg::op_t'(op)) inside
      mwsm_pkg::OP_TRANSLATE: begin
        s = clamp_to_limit(int'(spd));
        m = int'(ang) % 360;
        if (m < 0) m += 360;
        x = round_scaled(s, sine_of_degrees(m));
        y = round_scaled(s, sine_of_degrees((m + 90) % 360));
        w.one   = mwsm_pkg::WHEEL_W'(clamp_to_limit(y + x));
        w.two   = mwsm_pkg::WHEEL_W'(clamp_to_limit(y - x));
        w.three = mwsm_pkg::WHEEL_W'(clamp_to_limit(y - x));
        w.four  = mwsm_pkg::WHEEL_W'(clamp_to_limit(y + x));
      end
      mwsm_pkg::OP_TURN_LEFT, mwsm_pkg::OP_TURN_RIGHT: begin
        s = (mwsm_pkg::op_t'(op) == mwsm_pkg::OP_TURN_LEFT) ? int'(spd) : -int'(spd);
        w.one   = mwsm_pkg::WHEEL_W'(clamp_to_limit(s));
        w.two   = mwsm_pkg::WHEEL_W'(clamp_to_limit(-s));
        w.three = mwsm_pkg::WHEEL_W'(clamp_to_limit(s));
        w.four  = mwsm_pkg::WHEEL_W'(clamp_to_limit(-s));
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Compare one wheel field of a result item.
  task automatic check_wheel(input string wheel_name,
                             input logic signed [mwsm_pkg::WHEEL_W-1:0] got,
                             input logic signed [mwsm_pkg::WHEEL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                result_index, wheel_name, got, want));
  endtask

  // Retire results against the oldest prediction, then predict for accepted commands.
  always @(posedge clk) begin
    wheel_speeds_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_wheels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_index));
        end else begin
          want = expected_wheels.pop_front();
          check_wheel("wheel one", out_wheel_one_speed, want.one);
          check_wheel("wheel two", out_wheel_two_speed, want.two);
          check_wheel("wheel three", out_wheel_three_speed, want.three);
          check_wheel("wheel four", out_wheel_four_speed, want.four);
        end
        result_index++;
      end
      if (in_valid && in_ready)
        expected_wheels.push_back(mix_wheel_speeds(in_op, in_angle_degrees, in_speed));
      pending_results = expected_wheels.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the wheel mixer: clock, reset, command stimulus, output stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [mwsm_pkg::OP_W-1:0]            in_op = '0;
  logic signed [mwsm_pkg::ANGLE_W-1:0]  in_angle_degrees = '0;
  logic signed [mwsm_pkg::SPEED_W-1:0]  in_speed = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_one_speed;
  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_two_speed;
  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_three_speed;
  logic signed [mwsm_pkg::WHEEL_W-1:0]  out_wheel_four_speed;

  int fail_count;
  int pending_results;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int ready_hold_req = 0;
  int ready_hold_left = 0;

  mecanum_wheel_speed_mixer_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_angle_degrees      (in_angle_degrees),
    .in_speed              (in_speed),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wheel_one_speed   (out_wheel_one_speed),
    .out_wheel_two_speed   (out_wheel_two_speed),
    .out_wheel_three_speed (out_wheel_three_speed),
    .out_wheel_four_speed  (out_wheel_four_speed)
  );

  wheel_speed_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_angle_degrees      (in_angle_degrees),
    .in_speed              (in_speed),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wheel_one_speed   (out_wheel_one_speed),
    .out_wheel_two_speed   (out_wheel_two_speed),
    .out_wheel_three_speed (out_wheel_three_speed),
    .out_wheel_four_speed  (out_wheel_four_speed),
    .fail_count            (fail_count),
    .pending_results       (pending_results)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (ready_hold_req > 0) begin
      ready_hold_left = ready_hold_req;
      ready_hold_req  = 0;
    end
    if (ready_hold_left > 0) begin
      out_ready = 1'b0;
      ready_hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one command, with random idle cycles first, and return once it is accepted.
  task automatic send_command(input mwsm_pkg::op_t op,
                              input logic signed [mwsm_pkg::ANGLE_W-1:0] ang,
                              input logic signed [mwsm_pkg::SPEED_W-1:0] spd);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_op            = op;
    in_angle_degrees = ang;
    in_speed         = spd;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, then wait until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random command: mostly translates, angles mostly in the nominal range.
  task automatic send_random_command();
    mwsm_pkg::op_t                       op;
    logic signed [mwsm_pkg::ANGLE_W-1:0] ang;
    logic signed [mwsm_pkg::SPEED_W-1:0] spd;
    int                                  pick;
    pick = $urandom_range(99);
    if (pick < 60) op = mwsm_pkg::OP_TRANSLATE;
    else if (pick < 75) op = mwsm_pkg::OP_TURN_LEFT;
    else if (pick < 90) op = mwsm_pkg::OP_TURN_RIGHT;
    else op = mwsm_pkg::OP_STOP;
    if ($urandom_range(99) < 70) ang = mwsm_pkg::ANGLE_W'($urandom_range(720) - 360);
    else ang = mwsm_pkg::ANGLE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) spd = mwsm_pkg::SPEED_W'(-128);
    else if (pick < 20) spd = mwsm_pkg::SPEED_W'(127);
    else if (pick < 30) spd = mwsm_pkg::SPEED_W'($urandom_range(200) - 100);
    else spd = mwsm_pkg::SPEED_W'($urandom);
    send_command(op, ang, spd);
  endtask

  // Random phase with given sender idle and receiver stall rates.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_command();
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: quadrant edges, out-of-range angles, speed extremes, turns and stop.
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd0, 8'sd127);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd90, 8'sd100);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd180, -8'sd128);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd270, 8'sd1);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd359, -8'sd100);
    send_command(mwsm_pkg::OP_TRANSLATE, -10'sd360, 8'sd55);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd360, -8'sd1);
    send_command(mwsm_pkg::OP_TRANSLATE, -10'sd1, 8'sd77);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd45, 8'sd100);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd135, -8'sd99);
    send_command(mwsm_pkg::OP_TRANSLATE, -10'sd90, 8'sd0);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd511, 8'sd101);
    send_command(mwsm_pkg::OP_TRANSLATE, -10'sd512, -8'sd101);
    send_command(mwsm_pkg::OP_TRANSLATE, 10'sd30, 8'sd3);
    send_command(mwsm_pkg::OP_TURN_LEFT, 10'sd0, 8'sd127);
    send_command(mwsm_pkg::OP_TURN_LEFT, 10'sd511, -8'sd128);
    send_command(mwsm_pkg::OP_TURN_LEFT, -10'sd512, 8'sd37);
    send_command(mwsm_pkg::OP_TURN_RIGHT, 10'sd90, -8'sd128);
    send_command(mwsm_pkg::OP_TURN_RIGHT, -10'sd1, 8'sd127);
    send_command(mwsm_pkg::OP_TURN_RIGHT, 10'sd0, 8'sd0);
    send_command(mwsm_pkg::OP_STOP, -10'sd512, -8'sd128);
    send_command(mwsm_pkg::OP_STOP, 10'sd511, 8'sd127);
    drain_results();

    // Random phases: free running, idle sender, stalling receiver, light both.
    run_phase(0, 0, 350);
    run_phase(83, 0, 300);
    run_phase(0, 83, 350);
    run_phase(8, 8, 400);

    // Long receiver hold-off while commands keep coming, so the input backs up.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    ready_hold_req = 300;
    repeat (150) send_random_command();
    drain_results();

    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> mecanum_wheel_speed_mixer_top.f
design/mwsm_pkg.sv
design/mecanum_wheel_speed_mixer_top.sv
design/mwsm_checker.sv
verif/wheel_speed_checker.sv
verif/tb_top.sv
